FILE: rtl/hst_pkg.sv
// Shared definitions for the handle slot table: field widths, op and status
// codes, the decoded command kind and the queued command record.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package hst_pkg;

  // Field widths of the stream payload.
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 32;
  localparam int CTX_W    = 16;
  localparam int STATUS_W = 2;

  // Default table size and the group width of the free-slot scan.
  localparam int SLOTS_DEF = 256;
  localparam int GROUP_W   = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Op codes on the input channel.
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_RETIRE   = 2'd1;
  localparam logic [OP_W-1:0] OP_GRAB     = 2'd2;

  // Status codes on the result channel.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Command kind as decided by the front end.
  typedef enum logic [1:0] {
    KIND_REGISTER,
    KIND_RETIRE,
    KIND_GRAB,
    KIND_BAD
  } kind_t;

  // One queued command.
  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic [CTX_W-1:0]     ctx;
  } cmd_t;

endpackage

FILE: rtl/handle_slot_table_core.sv
// Top level of the handle slot table: stream ports, front end with command
// queue, and the back end that owns the table. Depends on hst_pkg,
// hst_front and hst_back.
`timescale 1ns / 1ps

// Maps 32-bit handles to 16-bit context ids in a table of SLOTS entries
// (a power of two); a handle always sits at slot handle AND (SLOTS-1).
// Register takes the first free slot at or above the running counter,
// retire frees a slot whose stored handle matches, grab reads it. Every
// input beat gives exactly one result beat. Retire, grab and the unused op
// read the handle/context memory through its registered read port before
// they answer. Register scans the free-slot bitmap in 16-slot groups, from
// the counter's group at or above the counter and then group by group, until
// a free slot turns up or the whole table has been seen and it reports full
// (the whole table is one group when SLOTS is below 16).
// Commands are handled one at a time; a two-beat queue lets the input accept
// beats while the back end works or a result waits to be taken.
// After reset every slot is empty and the counter is 1.
module handle_slot_table_core #(
  parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // handle [31:0], context_id [47:32]
  input  logic [7:0]  in_tuser,   // op [1:0], zero [7:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_handle [31:0], result_context [47:32]
  output logic [7:0]  out_tuser   // status [1:0], zero [7:2]
);

  logic                          q_valid;
  hst_pkg::cmd_t                 q_cmd;
  logic                          q_pop;
  logic [hst_pkg::STATUS_W-1:0]  res_status;
  logic [hst_pkg::HANDLE_W-1:0]  res_handle;
  logic [hst_pkg::CTX_W-1:0]     res_ctx;

  // Input beat decode and queue.
  hst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[hst_pkg::OP_W-1:0]),
    .in_handle (in_tdata[hst_pkg::HANDLE_W-1:0]),
    .in_ctx    (in_tdata[hst_pkg::HANDLE_W +: hst_pkg::CTX_W]),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Table execution and result register.
  hst_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (res_status),
    .out_handle (res_handle),
    .out_ctx    (res_ctx)
  );

  // Pack the result beat.
  assign out_tdata = {res_ctx, res_handle};
  assign out_tuser = {6'd0, res_status};

endmodule

FILE: rtl/hst_front.sv
// Front end of the handle slot table: accepts input beats, decodes the op
// into a command kind and holds commands in a short queue for the back end.
// Depends on hst_pkg.
`timescale 1ns / 1ps

module hst_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hst_pkg::OP_W-1:0]      in_op,
  input  logic [hst_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [hst_pkg::CTX_W-1:0]     in_ctx,
  output logic                          q_valid,
  output hst_pkg::cmd_t                 q_cmd,
  input  logic                          q_pop
);

  localparam int PTR_W = $clog2(hst_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hst_pkg::QUEUE_DEPTH + 1);

  hst_pkg::cmd_t        queue_r [hst_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  hst_pkg::cmd_t        in_cmd;
  logic                 push;
  logic                 pop;

  // Decode the op; the unused code becomes a command that always misses.
  always_comb begin
    in_cmd.handle = in_handle;
    in_cmd.ctx    = in_ctx;
    case (in_op)
      hst_pkg::OP_REGISTER: in_cmd.kind = hst_pkg::KIND_REGISTER;
      hst_pkg::OP_RETIRE:   in_cmd.kind = hst_pkg::KIND_RETIRE;
      hst_pkg::OP_GRAB:     in_cmd.kind = hst_pkg::KIND_GRAB;
      default:              in_cmd.kind = hst_pkg::KIND_BAD;
    endcase
  end

  assign in_tready = (count_r != CNT_W'(hst_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = queue_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: rtl/hst_back.sv
// Back end of the handle slot table: executes queued commands against the
// valid bitmap, the handle/context memory and the handle counter, and holds
// the result register. Depends on hst_pkg.
`timescale 1ns / 1ps

module hst_back #(
  parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  hst_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hst_pkg::STATUS_W-1:0]  out_status,
  output logic [hst_pkg::HANDLE_W-1:0]  out_handle,
  output logic [hst_pkg::CTX_W-1:0]     out_ctx
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int GW     = (SLOTS < hst_pkg::GROUP_W) ? SLOTS : hst_pkg::GROUP_W;
  localparam int GW_W   = $clog2(GW);
  localparam int NG     = SLOTS / GW;
  localparam int NG_W   = (NG > 1) ? $clog2(NG) : 1;
  localparam int CNT_W  = $clog2(NG + 1);
  localparam int DATA_W = hst_pkg::HANDLE_W + hst_pkg::CTX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_t;

  state_t                       state_r, state_nxt;
  hst_pkg::cmd_t                cur_r, cur_nxt;
  logic [NG-1:0][GW-1:0]        valid_r, valid_nxt;
  logic [hst_pkg::HANDLE_W-1:0] next_handle_r, next_handle_nxt;
  logic [NG_W-1:0]              scan_grp_r, scan_grp_nxt;
  logic [CNT_W-1:0]             scan_cnt_r, scan_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hst_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [hst_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [hst_pkg::CTX_W-1:0]    out_ctx_r, out_ctx_nxt;

  logic [DATA_W-1:0]            mem [SLOTS];
  logic [DATA_W-1:0]            rd_r;
  logic [IDX_W-1:0]             rd_addr;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [DATA_W-1:0]            mem_wdata;

  logic [IDX_W-1:0]             head_slot;
  logic [IDX_W-1:0]             cur_slot;
  logic [IDX_W-1:0]             start_slot;
  logic [GW_W-1:0]              start_bit;
  logic                         out_free;
  logic                         hit;
  logic [GW-1:0]                free_bits;
  logic [GW_W-1:0]              free_pos;
  logic                         found;
  logic [IDX_W-1:0]             found_slot;
  logic [IDX_W-1:0]             probe_ofs;
  logic [hst_pkg::HANDLE_W-1:0] cand;

  function automatic logic [NG_W-1:0] grp_of(input logic [IDX_W-1:0] s);
    grp_of = NG_W'(s >> GW_W);
  endfunction

  function automatic logic [GW_W-1:0] bit_of(input logic [IDX_W-1:0] s);
    bit_of = GW_W'(s);
  endfunction

  assign head_slot  = IDX_W'(q_cmd.handle);
  assign cur_slot   = IDX_W'(cur_r.handle);
  assign start_slot = IDX_W'(next_handle_r);
  assign start_bit  = bit_of(start_slot);
  assign out_free   = !out_valid_r || out_tready;
  assign rd_addr    = (state_r == ST_IDLE) ? head_slot : cur_slot;

  // Lookup compare against the registered memory word.
  assign hit = valid_r[grp_of(cur_slot)][bit_of(cur_slot)] &&
               (rd_r[hst_pkg::HANDLE_W-1:0] == cur_r.handle);

  // Free bits of the group under scan. The group that holds the counter's
  // slot is seen twice: first from the counter upward, last below it.
  always_comb begin
    logic first_pass;
    logic last_pass;
    first_pass = (scan_cnt_r == '0);
    last_pass  = (scan_cnt_r == CNT_W'(NG));
    for (int j = 0; j < GW; j++) begin
      if (first_pass) begin
        free_bits[j] = !valid_r[scan_grp_r][j] && (GW_W'(j) >= start_bit);
      end else if (last_pass) begin
        free_bits[j] = !valid_r[scan_grp_r][j] && (GW_W'(j) < start_bit);
      end else begin
        free_bits[j] = !valid_r[scan_grp_r][j];
      end
    end
  end

  // Lowest free bit of the group.
  always_comb begin
    free_pos = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        free_pos = GW_W'(j);
      end
    end
  end

  assign found      = |free_bits;
  assign found_slot = IDX_W'({scan_grp_r, free_pos});
  assign probe_ofs  = found_slot - start_slot;
  assign cand       = next_handle_r + hst_pkg::HANDLE_W'(probe_ofs);

  // Command sequencer.
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    valid_nxt       = valid_r;
    next_handle_nxt = next_handle_r;
    scan_grp_nxt    = scan_grp_r;
    scan_cnt_nxt    = scan_cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_handle_nxt  = out_handle_r;
    out_ctx_nxt     = out_ctx_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = found_slot;
    mem_wdata       = {cur_r.ctx, cand};

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          case (q_cmd.kind)
            hst_pkg::KIND_REGISTER: begin
              scan_grp_nxt = grp_of(start_slot);
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            hst_pkg::KIND_RETIRE, hst_pkg::KIND_GRAB: begin
              state_nxt = ST_LOOK;
            end
            default: begin
              // Unknown op: the whole miss path runs through the lookup state.
              state_nxt = ST_LOOK;
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = cur_r.handle;
          if (hit && (cur_r.kind inside {hst_pkg::KIND_RETIRE, hst_pkg::KIND_GRAB})) begin
            out_status_nxt = hst_pkg::STATUS_OK;
            out_ctx_nxt    = rd_r[hst_pkg::HANDLE_W +: hst_pkg::CTX_W];
            if (cur_r.kind == hst_pkg::KIND_RETIRE) begin
              valid_nxt[grp_of(cur_slot)][bit_of(cur_slot)] = 1'b0;
            end
          end else begin
            out_status_nxt = hst_pkg::STATUS_MISS;
            out_ctx_nxt    = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (found) begin
          if (out_free) begin
            mem_we          = 1'b1;
            valid_nxt[scan_grp_r][free_pos] = 1'b1;
            next_handle_nxt = cand + 1'b1;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = hst_pkg::STATUS_OK;
            out_handle_nxt  = cand;
            out_ctx_nxt     = '0;
            state_nxt       = ST_IDLE;
          end
        end else if (scan_cnt_r == CNT_W'(NG)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = hst_pkg::STATUS_FULL;
            out_handle_nxt = '0;
            out_ctx_nxt    = '0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_grp_nxt = (scan_grp_r == NG_W'(NG - 1)) ? '0 : scan_grp_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, bitmap, counter and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      next_handle_r <= hst_pkg::HANDLE_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      valid_r       <= valid_nxt;
      next_handle_r <= next_handle_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    scan_grp_r   <= scan_grp_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_ctx_r    <= out_ctx_nxt;
  end

  // Handle and context memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;
  assign out_ctx    = out_ctx_r;

endmodule
